[rtl/core/avtb_pkg.sv]
// avtb_pkg: shared types and constants for the affine vertex transform block
// used by avtb_axis_path and affine_vertex_transform_bounds; no dependencies
`timescale 1ns / 1ps

package avtb_pkg;

  // coefficients are signed with twelve fraction bits
  localparam int FRAC_SHIFT = 12;
  localparam int NUM_AXES   = 3;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_COEFFS = 3'd0,
    CFG_Y_COEFFS = 3'd1,
    CFG_Z_COEFFS = 3'd2,
    CFG_X_OFFSET = 3'd3,
    CFG_Y_OFFSET = 3'd4,
    CFG_Z_OFFSET = 3'd5
  } cfg_reg_e;

  // load enables for the datapath stages after the input register
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } pipe_en_t;

endpackage

[rtl/core/avtb_axis_path.sv]
// avtb_axis_path: datapath for one output axis (products, rounding, offset, saturation)
// depends on avtb_pkg; three registered stages driven by the top level's load enables
`timescale 1ns / 1ps

module avtb_axis_path import avtb_pkg::*; #(
  parameter int COORD_WIDTH = 24,
  parameter int COEF_WIDTH  = 16
) (
  input  logic                          clk_i,
  input  pipe_en_t                      pipe_en_i,
  input  logic signed [COORD_WIDTH-1:0] coord_i [NUM_AXES],
  input  logic [3*COEF_WIDTH-1:0]       coeffs_i,
  input  logic signed [COORD_WIDTH-1:0] offset_i,
  output logic signed [COORD_WIDTH-1:0] result_o
);

  localparam int PW = COORD_WIDTH + COEF_WIDTH;
  localparam int SW = PW + 2;
  localparam int RW = SW - FRAC_SHIFT;
  localparam int AW = ((RW > COORD_WIDTH) ? RW : COORD_WIDTH) + 1;

  localparam logic signed [SW-1:0] RND_HALF = SW'(1) << (FRAC_SHIFT - 1);
  localparam logic signed [AW-1:0] SAT_MAX =
    {{(AW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [AW-1:0] SAT_MIN =
    {{(AW-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

  logic signed [COEF_WIDTH-1:0]  coef     [NUM_AXES];
  logic signed [PW-1:0]          prod_d   [NUM_AXES];
  logic signed [PW-1:0]          prod_q   [NUM_AXES];
  logic signed [SW-1:0]          sum;
  logic signed [RW-1:0]          rnd_q;
  logic signed [AW-1:0]          acc;
  logic signed [COORD_WIDTH-1:0] res_d;
  logic signed [COORD_WIDTH-1:0] res_q;

  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      coef[k]   = $signed(coeffs_i[k*COEF_WIDTH +: COEF_WIDTH]);
      prod_d[k] = PW'(coord_i[k]) * PW'(coef[k]);
    end
  end

  // floor of (sum + half) >> frac is the upper slice of the two's complement sum
  assign sum = SW'(prod_q[0]) + SW'(prod_q[1]) + SW'(prod_q[2]) + RND_HALF;
  assign acc = AW'(rnd_q) + AW'(offset_i);

  always_comb begin
    if (acc > SAT_MAX) begin
      res_d = SAT_MAX[COORD_WIDTH-1:0];
    end else if (acc < SAT_MIN) begin
      res_d = SAT_MIN[COORD_WIDTH-1:0];
    end else begin
      res_d = acc[COORD_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en_i.s2) begin
      prod_q <= prod_d;
    end
    if (pipe_en_i.s3) begin
      rnd_q <= sum[SW-1:FRAC_SHIFT];
    end
    if (pipe_en_i.s4) begin
      res_q <= res_d;
    end
  end

  assign result_o = res_q;

endmodule

[rtl/core/affine_vertex_transform_bounds.sv]
// affine_vertex_transform_bounds: top level, stream ports, config registers, bounds tracking
// depends on avtb_pkg and avtb_axis_path (one instance per output axis)
//
// Usage:
//   Input beats on the s_axis group carry one vertex (x, y, z, signed Q16.8) in
//   tdata and the first-vertex flag in tuser. Each vertex yields one output beat on
//   m_axis: the transformed vertex (3x3 Q4.12 matrix, rounded, plus offset,
//   saturated) and the running min/max per axis after this vertex.
//   A vertex with the flag set restarts the bounds from itself.
//   Pipeline: a beat accepted into the input register passes through the product
//   register, rounding register and saturation register to the output register,
//   from which it is presented on m_axis. Throughput: one vertex per cycle while
//   m_axis takes beats, set by the five-stage pipeline with the bounds compare loop at the output.
//   Stalls: each stage loads whenever it is empty or the stage after it moves, so
//   bubbles close up while m_axis_tready is low; s_axis_tready drops only once all
//   five stages hold data.
//   Config: cfg port writes one register per beat (cfg_ready_o is always high);
//   write only while the pipeline is empty. Unknown indexes are ignored.
//   Reset: valids clear, matrix resets to identity, offsets and bounds to zero.
`timescale 1ns / 1ps

module affine_vertex_transform_bounds import avtb_pkg::*; #(
  parameter int COORD_WIDTH = 24,
  parameter int COEF_WIDTH  = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // in_x, in_y, in_z, zero padding
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // first_vertex
  input  logic                     s_axis_tuser,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // out_x, out_y, out_z, min_x, max_x, min_y, max_y, min_z, max_z, zero padding
  output logic [((9*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [((3*COEF_WIDTH > COORD_WIDTH) ? 3*COEF_WIDTH : COORD_WIDTH)-1:0] cfg_data_i
);

  localparam int CW     = COORD_WIDTH;
  localparam int KW     = 3 * COEF_WIDTH;
  localparam int OUT_TW = ((9*CW+7)/8)*8;

  localparam logic [KW-1:0] X_COEF_RST = KW'(64'd1 << FRAC_SHIFT);
  localparam logic [KW-1:0] Y_COEF_RST = KW'((64'd1 << FRAC_SHIFT) << COEF_WIDTH);
  localparam logic [KW-1:0] Z_COEF_RST = KW'((64'd1 << FRAC_SHIFT) << (2*COEF_WIDTH));

  logic [KW-1:0]        coef_q [NUM_AXES];
  logic signed [CW-1:0] offs_q [NUM_AXES];

  logic signed [CW-1:0] in_q   [NUM_AXES];
  logic signed [CW-1:0] sat    [NUM_AXES];
  logic signed [CW-1:0] out_q  [NUM_AXES];
  logic signed [CW-1:0] lo_q   [NUM_AXES];
  logic signed [CW-1:0] hi_q   [NUM_AXES];
  logic signed [CW-1:0] lo_d   [NUM_AXES];
  logic signed [CW-1:0] hi_d   [NUM_AXES];

  logic v1_q, v2_q, v3_q, v4_q, vo_q;
  logic f1_q, f2_q, f3_q, f4_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy_o;
  logic en1, en_o;
  pipe_en_t pipe_en;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[0] <= X_COEF_RST;
      coef_q[1] <= Y_COEF_RST;
      coef_q[2] <= Z_COEF_RST;
      for (int a = 0; a < NUM_AXES; a++) begin
        offs_q[a] <= '0;
      end
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_X_COEFFS: coef_q[0] <= cfg_data_i[KW-1:0];
        CFG_Y_COEFFS: coef_q[1] <= cfg_data_i[KW-1:0];
        CFG_Z_COEFFS: coef_q[2] <= cfg_data_i[KW-1:0];
        CFG_X_OFFSET: offs_q[0] <= $signed(cfg_data_i[CW-1:0]);
        CFG_Y_OFFSET: offs_q[1] <= $signed(cfg_data_i[CW-1:0]);
        CFG_Z_OFFSET: offs_q[2] <= $signed(cfg_data_i[CW-1:0]);
        default: ;
      endcase
    end
  end

  // per-stage flow control: a stage loads when empty or when its successor moves
  assign rdy_o = !vo_q || m_axis_tready;
  assign rdy4  = !v4_q || rdy_o;
  assign rdy3  = !v3_q || rdy4;
  assign rdy2  = !v2_q || rdy3;
  assign rdy1  = !v1_q || rdy2;

  assign s_axis_tready = rdy1;
  assign en1           = s_axis_tvalid && rdy1;
  assign pipe_en.s2    = v1_q && rdy2;
  assign pipe_en.s3    = v2_q && rdy3;
  assign pipe_en.s4    = v3_q && rdy4;
  assign en_o          = v4_q && rdy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1)  v1_q <= s_axis_tvalid;
      if (rdy2)  v2_q <= v1_q;
      if (rdy3)  v3_q <= v2_q;
      if (rdy4)  v4_q <= v3_q;
      if (rdy_o) vo_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      in_q[0] <= $signed(s_axis_tdata[CW-1:0]);
      in_q[1] <= $signed(s_axis_tdata[2*CW-1:CW]);
      in_q[2] <= $signed(s_axis_tdata[3*CW-1:2*CW]);
      f1_q    <= s_axis_tuser;
    end
    if (pipe_en.s2) f2_q <= f1_q;
    if (pipe_en.s3) f3_q <= f2_q;
    if (pipe_en.s4) f4_q <= f3_q;
    if (en_o) begin
      out_q <= sat;
    end
  end

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    avtb_axis_path #(
      .COORD_WIDTH (COORD_WIDTH),
      .COEF_WIDTH  (COEF_WIDTH)
    ) u_path (
      .clk_i     (clk_i),
      .pipe_en_i (pipe_en),
      .coord_i   (in_q),
      .coeffs_i  (coef_q[a]),
      .offset_i  (offs_q[a]),
      .result_o  (sat[a])
    );
  end

  // running bounds; they double as the output bound fields
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      lo_d[a] = lo_q[a];
      hi_d[a] = hi_q[a];
      if (f4_q) begin
        lo_d[a] = sat[a];
        hi_d[a] = sat[a];
      end else if (sat[a] < lo_q[a]) begin
        lo_d[a] = sat[a];
      end else if (sat[a] > hi_q[a]) begin
        hi_d[a] = sat[a];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        lo_q[a] <= '0;
        hi_q[a] <= '0;
      end
    end else if (en_o) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = OUT_TW'({hi_q[2], lo_q[2], hi_q[1], lo_q[1], hi_q[0], lo_q[0],
                                  out_q[2], out_q[1], out_q[0]});

`ifndef ASSERT_OFF
  a_bounds_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lo_q[0] <= hi_q[0] && lo_q[1] <= hi_q[1] && lo_q[2] <= hi_q[2])
    else $error("bounds min above max");

  a_first_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_o && f4_q |=> lo_q[0] == out_q[0] && hi_q[0] == out_q[0] &&
                     lo_q[1] == out_q[1] && hi_q[1] == out_q[1] &&
                     lo_q[2] == out_q[2] && hi_q[2] == out_q[2])
    else $error("first vertex did not restart bounds");

  a_vertex_in_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_o |=> lo_q[0] <= out_q[0] && out_q[0] <= hi_q[0] &&
             lo_q[1] <= out_q[1] && out_q[1] <= hi_q[1] &&
             lo_q[2] <= out_q[2] && out_q[2] <= hi_q[2])
    else $error("output vertex outside its bounds");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> v1_q && v2_q && v3_q && v4_q && vo_q && !m_axis_tready)
    else $error("input stalled with a free pipeline stage");
`endif

endmodule
